// ===== sv/rtc_pkg.sv =====
// Shared types and constants for the real-time clock block.
`default_nettype none

package rtc_pkg;

	localparam int unsigned SEC_W    = 32;
	localparam int unsigned DIV_W    = 20;
	localparam int unsigned MS_W     = 10;
	localparam int unsigned FLAG_W   = 3;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned CFG_IX_W = 2;
	localparam int unsigned CFG_D_W  = 32;
	localparam int unsigned BIT_IX_W = $clog2(SEC_W);

	localparam logic [DIV_W-1:0]  RELOAD_RST = DIV_W'(32767);
	localparam logic [SEC_W-1:0]  ALARM_RST  = {SEC_W{1'b1}};
	localparam logic [FLAG_W-1:0] IRQ_EN_RST = '0;

	localparam int unsigned FLAG_SEC = 0;
	localparam int unsigned FLAG_ALR = 1;
	localparam int unsigned FLAG_OVF = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IX_W-1:0] {
		CFG_RELOAD = 2'd0,
		CFG_ALARM  = 2'd1,
		CFG_IRQ_EN = 2'd2
	} cfg_ix_t;

	typedef struct packed {
		logic alarm_hit;
		logic wrapped;
	} sec_stat_t;

	typedef struct packed {
		logic start;
		logic inc;
		logic load;
		logic step;
	} sec_ctl_t;

endpackage

`default_nettype wire

// ===== sv/rtc_in_if.sv =====
// Request channel into the real-time clock.
`default_nettype none

interface rtc_in_if;
	logic                       valid;
	logic                       ready;
	logic [rtc_pkg::CMD_W-1:0]  cmd;
	logic [rtc_pkg::SEC_W-1:0]  load_value;
	logic [rtc_pkg::FLAG_W-1:0] clear_mask;

	modport source (output valid, cmd, load_value, clear_mask, input ready);
	modport sink (input valid, cmd, load_value, clear_mask, output ready);
endinterface

`default_nettype wire

// ===== sv/rtc_out_if.sv =====
// Result channel out of the real-time clock.
`default_nettype none

interface rtc_out_if;
	logic                       valid;
	logic                       ready;
	logic [rtc_pkg::SEC_W-1:0]  seconds;
	logic [rtc_pkg::DIV_W-1:0]  divider;
	logic [rtc_pkg::MS_W-1:0]   milliseconds;
	logic [rtc_pkg::FLAG_W-1:0] pending_flags;
	logic                       irq;

	modport source (output valid, seconds, divider, milliseconds, pending_flags, irq,
		input ready);
	modport sink (input valid, seconds, divider, milliseconds, pending_flags, irq,
		output ready);
endinterface

`default_nettype wire

// ===== sv/rtc_second_counter_alarm.sv =====
// Real-time clock top level: prescaler, seconds counter, alarm and interrupt flags.
// Each request runs from acceptance to a ready result as follows: the seconds counter
// (loaded on a load request) is incremented on a tick with the divider at zero and is
// compared with the alarm one bit per cycle in the run state, with the milliseconds
// divider running alongside; the done state then updates the flags on a counter advance
// and the output state loads the result register. A new request is accepted only in the
// idle state; a stalled result holds the block in the output step until the result
// register is free. A finished result waits in that register while the next request is
// accepted. Write configuration only while no request is in progress.
`default_nettype none

module rtc_second_counter_alarm (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	rtc_in_if.sink                              in_ch,
	rtc_out_if.source                           out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [rtc_pkg::CFG_IX_W-1:0]   cfg_index,
	input  wire logic [rtc_pkg::CFG_D_W-1:0]    cfg_wdata
);
	import rtc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE,
		S_OUT
	} top_state_t;

	top_state_t        state_q;
	logic [BIT_IX_W-1:0] cnt_q;
	logic [DIV_W-1:0]  reload_q;
	logic [SEC_W-1:0]  alarm_q;
	logic [FLAG_W-1:0] irq_en_q;
	logic [DIV_W-1:0]  div_q;
	logic [FLAG_W-1:0] flags_q;
	logic              inc_q;
	logic              out_valid_q;
	logic [SEC_W-1:0]  out_sec_q;
	logic [DIV_W-1:0]  out_div_q;
	logic [MS_W-1:0]   out_ms_q;
	logic [FLAG_W-1:0] out_flags_q;
	logic              out_irq_q;

	logic              accept;
	logic              is_tick;
	logic              div_zero;
	sec_ctl_t          sec_ctl;
	sec_stat_t         sec_stat;
	logic [SEC_W-1:0]  sec_val;
	logic              ms_done;
	logic [MS_W-1:0]   ms_val;
	logic              out_free;

	assign accept   = in_ch.valid & in_ch.ready;
	assign is_tick  = in_ch.cmd == CMD_TICK;
	assign div_zero = div_q == '0;
	assign out_free = !out_valid_q || out_ch.ready;

	assign sec_ctl.start = accept;
	assign sec_ctl.inc   = is_tick && div_zero;
	assign sec_ctl.load  = in_ch.cmd == CMD_LOAD;
	assign sec_ctl.step  = state_q == S_RUN;

	rtc_sec_serial u_sec (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (sec_ctl),
		.load_value  (in_ch.load_value),
		.alarm_value (alarm_q),
		.bit_ix      (cnt_q),
		.seconds     (sec_val),
		.stat        (sec_stat)
	);

	rtc_ms_div u_ms (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == S_RUN && cnt_q == '0),
		.reload       (reload_q),
		.div_count    (div_q),
		.done         (ms_done),
		.milliseconds (ms_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RST;
			alarm_q  <= ALARM_RST;
			irq_en_q <= IRQ_EN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RELOAD: reload_q <= cfg_wdata[DIV_W-1:0];
				CFG_ALARM:  alarm_q  <= cfg_wdata[SEC_W-1:0];
				CFG_IRQ_EN: irq_en_q <= cfg_wdata[FLAG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			div_q       <= '0;
			flags_q     <= '0;
			inc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						inc_q   <= sec_ctl.inc;
						state_q <= S_RUN;
						case (in_ch.cmd)
							CMD_TICK: begin
								if (div_zero) begin
									div_q <= reload_q;
								end else begin
									div_q <= div_q - 1'b1;
								end
							end
							CMD_CLEAR: flags_q <= flags_q & ~in_ch.clear_mask;
							default: ;
						endcase
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BIT_IX_W'(SEC_W-1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (inc_q) begin
						flags_q[FLAG_SEC] <= 1'b1;
						flags_q[FLAG_ALR] <= flags_q[FLAG_ALR] | sec_stat.alarm_hit;
						flags_q[FLAG_OVF] <= flags_q[FLAG_OVF] | sec_stat.wrapped;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_sec_q   <= sec_val;
						out_div_q   <= div_q;
						out_ms_q    <= ms_val;
						out_flags_q <= flags_q;
						out_irq_q   <= |(flags_q & irq_en_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready          = state_q == S_IDLE;
	assign out_ch.valid         = out_valid_q;
	assign out_ch.seconds       = out_sec_q;
	assign out_ch.divider       = out_div_q;
	assign out_ch.milliseconds  = out_ms_q;
	assign out_ch.pending_flags = out_flags_q;
	assign out_ch.irq           = out_irq_q;

	a_ms_ready_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> ms_done)
		else $error("milliseconds not ready when the count finishes");

	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RUN && cnt_q == '0)
		else $error("accepted request did not start the serial pass");

	a_run_ends_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN && cnt_q == BIT_IX_W'(SEC_W-1) |=> state_q == S_DONE)
		else $error("serial pass length wrong");

	a_second_flag_on_carry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && inc_q |=> flags_q[FLAG_SEC])
		else $error("second flag not raised on a counter advance");

endmodule

`default_nettype wire

// ===== sv/rtc_sec_serial.sv =====
// Bit-serial seconds counter with increment, alarm compare and wrap detect.
`default_nettype none

module rtc_sec_serial (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rtc_pkg::sec_ctl_t             ctl,
	input  wire logic [rtc_pkg::SEC_W-1:0]     load_value,
	input  wire logic [rtc_pkg::SEC_W-1:0]     alarm_value,
	input  wire logic [rtc_pkg::BIT_IX_W-1:0]  bit_ix,
	output logic [rtc_pkg::SEC_W-1:0]          seconds,
	output rtc_pkg::sec_stat_t                 stat
);
	import rtc_pkg::*;

	logic [SEC_W-1:0] sec_q;
	logic             carry_q;
	logic             eq_q;
	logic             zero_q;
	logic             new_bit;

	assign new_bit = sec_q[0] ^ carry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= '0;
			carry_q <= 1'b0;
			eq_q    <= 1'b0;
			zero_q  <= 1'b0;
		end else if (ctl.start) begin
			carry_q <= ctl.inc;
			eq_q    <= 1'b1;
			zero_q  <= 1'b1;
			if (ctl.load) begin
				sec_q <= load_value;
			end
		end else if (ctl.step) begin
			sec_q   <= {new_bit, sec_q[SEC_W-1:1]};
			carry_q <= sec_q[0] & carry_q;
			eq_q    <= eq_q & (new_bit == alarm_value[bit_ix]);
			zero_q  <= zero_q & ~new_bit;
		end
	end

	assign seconds        = sec_q;
	assign stat.alarm_hit = eq_q;
	assign stat.wrapped   = zero_q;

	a_no_carry_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start && ctl.load |=> !carry_q)
		else $error("carry armed on a load request");

	a_step_not_start: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.start && ctl.step))
		else $error("start and step together");

	a_zero_tracks_value: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && bit_ix == BIT_IX_W'(SEC_W-1) |=> zero_q == (sec_q == '0))
		else $error("wrap detect disagrees with count");

endmodule

`default_nettype wire

// ===== sv/rtc_ms_div.sv =====
// Milliseconds fraction: constant multiply then one quotient bit per cycle.
`default_nettype none

module rtc_ms_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rtc_pkg::DIV_W-1:0]   reload,
	input  wire logic [rtc_pkg::DIV_W-1:0]   div_count,
	output logic                             done,
	output logic [rtc_pkg::MS_W-1:0]         milliseconds
);
	import rtc_pkg::*;

	localparam int unsigned NUM_W = DIV_W + MS_W;
	localparam int unsigned K_W   = $clog2(MS_W);

	typedef enum logic [1:0] {
		M_IDLE,
		M_MUL,
		M_DIV
	} ms_state_t;

	ms_state_t        state_q;
	logic [DIV_W-1:0] x_q;
	logic [DIV_W:0]   d_q;
	logic             over_q;
	logic [DIV_W:0]   r_q;
	logic [MS_W-1:0]  lo_q;
	logic [MS_W-1:0]  q_q;
	logic [K_W-1:0]   k_q;
	logic             done_q;
	logic [NUM_W-1:0] num;
	logic [DIV_W+1:0] trial;
	logic [DIV_W+1:0] diff;
	logic             ge;

	assign num   = {x_q, 10'b0} - NUM_W'({x_q, 4'b0}) - NUM_W'({x_q, 3'b0});
	assign trial = {r_q, lo_q[MS_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
			over_q  <= 1'b0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (start) begin
						done_q  <= 1'b0;
						over_q  <= div_count > reload;
						x_q     <= reload - div_count;
						d_q     <= {1'b0, reload} + 1'b1;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					r_q     <= {1'b0, num[NUM_W-1:MS_W]};
					lo_q    <= num[MS_W-1:0];
					q_q     <= '0;
					k_q     <= '0;
					state_q <= M_DIV;
				end
				M_DIV: begin
					r_q  <= ge ? diff[DIV_W:0] : trial[DIV_W:0];
					q_q  <= {q_q[MS_W-2:0], ge};
					lo_q <= {lo_q[MS_W-2:0], 1'b0};
					k_q  <= k_q + 1'b1;
					if (k_q == K_W'(MS_W-1)) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done         = done_q;
	assign milliseconds = over_q ? '0 : q_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == M_DIV && !over_q |-> r_q < d_q)
		else $error("partial remainder not below divisor");

	a_done_clears_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == M_IDLE && start |=> !done_q)
		else $error("done left high after a new start");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> milliseconds < MS_W'(1000))
		else $error("milliseconds out of range");

endmodule

`default_nettype wire
